// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the top-level unit, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked out of reset
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== design/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fbpa_pkg
// types, codes and widths of the fixed block pool allocator
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int MAX_BLOCKS_DFLT = 256;

    localparam int CMD_W     = 2;
    localparam int IDX_W     = 8;
    localparam int STATUS_W  = 2;
    localparam int CNT_W     = 9;
    localparam int SIZE_W    = 16;
    localparam int ADDR_W    = 32;
    localparam int BYTES_W   = 24;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELOAD = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_ALLOC = 2'd2;

    // register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_BLOCK_COUNT  = 2'd0;
    localparam logic [1:0] REG_BLOCK_SIZE   = 2'd1;
    localparam logic [1:0] REG_BASE_ADDRESS = 2'd2;

    // reset values of the registers
    localparam logic [CNT_W-1:0]  BLOCK_COUNT_RST  = 9'd256;
    localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST   = 16'd64;
    localparam logic [ADDR_W-1:0] BASE_ADDRESS_RST = 32'd0;

    // classified operation carried from front to back
    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_RELOAD,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] block_index;
    } t_entry;

    // head of the item queue as seen by the back end
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_q_head;

endpackage

// ===== design/fbpa_front.sv =====
// ----------------------------------------------------------------------------
// fbpa_front
// accepts items, decodes the command and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module fbpa_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [fbpa_pkg::CMD_W-1:0]        i_cmd,
    input  logic [fbpa_pkg::IDX_W-1:0]        i_block_index,
    output fbpa_pkg::t_q_head                 o_head,
    input  logic                              i_pop
);

    localparam int DEPTH = 2;

    fbpa_pkg::t_entry r_q [DEPTH];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic [1:0]       n_count;
    fbpa_pkg::t_entry w_entry;
    logic             w_push;

    // decode
    always_comb begin
        w_entry.block_index = i_block_index;
        case (i_cmd)
            fbpa_pkg::CMD_ALLOC:  w_entry.op = fbpa_pkg::OP_ALLOC;
            fbpa_pkg::CMD_FREE:   w_entry.op = fbpa_pkg::OP_FREE;
            fbpa_pkg::CMD_RELOAD: w_entry.op = fbpa_pkg::OP_RELOAD;
            default:              w_entry.op = fbpa_pkg::OP_NOP;
        endcase
    end

    assign busy   = (r_count == 2'(DEPTH));
    assign w_push = start && !busy;

    always_comb begin
        n_count = r_count;
        if (w_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_entry;
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.entry = r_q[r_rd_ptr];

endmodule

// ===== design/fbpa_back.sv =====
// ----------------------------------------------------------------------------
// fbpa_back
// free-list stack, block counters and result formation
// ----------------------------------------------------------------------------
module fbpa_back #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DFLT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fbpa_pkg::t_q_head                   i_head,
    output logic                                o_pop,
    input  logic [fbpa_pkg::CNT_W-1:0]          i_block_count,
    input  logic [fbpa_pkg::SIZE_W-1:0]         i_block_size,
    input  logic [fbpa_pkg::ADDR_W-1:0]         i_base_address,
    output logic                                o_strobe,
    output logic [fbpa_pkg::STATUS_W-1:0]       o_status,
    output logic [fbpa_pkg::IDX_W-1:0]          o_granted_index,
    output logic [fbpa_pkg::ADDR_W-1:0]         o_granted_address,
    output logic [fbpa_pkg::BYTES_W-1:0]        o_used_bytes,
    output logic [fbpa_pkg::BYTES_W-1:0]        o_peak_bytes
);

    localparam int CW   = $clog2(MAX_BLOCKS + 1);
    localparam int AW   = $clog2(MAX_BLOCKS);
    localparam int PW   = CW + fbpa_pkg::SIZE_W;
    localparam int GPW  = fbpa_pkg::IDX_W + fbpa_pkg::SIZE_W;
    localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_OUT
    } t_state;

    t_state                           r_state;
    logic [CW-1:0]                    r_free;
    logic [CW-1:0]                    r_used;
    logic [CW-1:0]                    r_peak;
    logic [CW-1:0]                    r_lo;
    logic                             r_ok;
    logic [fbpa_pkg::STATUS_W-1:0]    r_status;
    logic                             r_virt;
    logic [fbpa_pkg::IDX_W-1:0]       r_virt_val;
    logic [fbpa_pkg::IDX_W-1:0]       r_gidx;
    logic [GPW-1:0]                   r_prod_addr;
    logic [PW-1:0]                    r_prod_used;
    logic [PW-1:0]                    r_prod_peak;
    logic [fbpa_pkg::IDX_W-1:0]       r_rd_data;
    logic [fbpa_pkg::IDX_W-1:0]       r_mem [MAX_BLOCKS];

    fbpa_pkg::t_entry                 w_e;
    logic [CW-1:0]                    w_top;
    logic [CW-1:0]                    w_used_inc;
    logic [CW-1:0]                    w_reload_n;
    logic [fbpa_pkg::IDX_W-1:0]       w_blk;
    logic                             w_mem_re;
    logic                             w_mem_we;

    assign w_e        = i_head.entry;
    assign o_pop      = (r_state == S_IDLE) && i_head.valid;
    assign w_top      = r_free - CW'(1);
    assign w_used_inc = r_used + CW'(1);
    assign w_reload_n = ({23'd0, i_block_count} > 32'(MAX_BLOCKS)) ? MAXC
                                                                   : CW'(i_block_count);
    assign w_mem_re   = o_pop && (w_e.op == fbpa_pkg::OP_ALLOC) && (r_free != '0);
    assign w_mem_we   = o_pop && (w_e.op == fbpa_pkg::OP_FREE) && (r_used != '0)
                        && (r_free < MAXC);
    // entries below the reload mark still hold their own index
    assign w_blk      = r_virt ? r_virt_val : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_free[AW-1:0]] <= w_e.block_index;
        end
        if (w_mem_re) begin
            r_rd_data <= r_mem[w_top[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_free   <= '0;
            r_used   <= '0;
            r_peak   <= '0;
            r_lo     <= '0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_state  <= S_MUL;
                        r_ok     <= 1'b0;
                        r_status <= fbpa_pkg::ST_OK;
                        case (w_e.op)
                            fbpa_pkg::OP_ALLOC: begin
                                if (r_free == '0) begin
                                    r_status <= fbpa_pkg::ST_FULL;
                                end else begin
                                    r_ok       <= 1'b1;
                                    r_free     <= w_top;
                                    r_used     <= w_used_inc;
                                    r_virt     <= (w_top < r_lo);
                                    r_virt_val <= fbpa_pkg::IDX_W'(w_top);
                                    if (w_used_inc > r_peak) begin
                                        r_peak <= w_used_inc;
                                    end
                                end
                            end
                            fbpa_pkg::OP_FREE: begin
                                if (r_used == '0) begin
                                    r_status <= fbpa_pkg::ST_NO_ALLOC;
                                end else begin
                                    r_used <= r_used - CW'(1);
                                    if (r_free < MAXC) begin
                                        r_free <= r_free + CW'(1);
                                        if (r_free < r_lo) begin
                                            r_lo <= r_free;
                                        end
                                    end
                                end
                            end
                            fbpa_pkg::OP_RELOAD: begin
                                r_free <= w_reload_n;
                                r_lo   <= w_reload_n;
                                r_used <= '0;
                                r_peak <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_state     <= S_OUT;
                    r_gidx      <= r_ok ? w_blk : '0;
                    r_prod_addr <= GPW'(w_blk) * GPW'(i_block_size);
                    r_prod_used <= PW'(r_used) * PW'(i_block_size);
                    r_prod_peak <= PW'(r_peak) * PW'(i_block_size);
                end
                S_OUT: begin
                    r_state           <= S_IDLE;
                    o_strobe          <= 1'b1;
                    o_status          <= r_status;
                    o_granted_index   <= r_gidx;
                    o_granted_address <= r_ok ? (i_base_address
                                                 + fbpa_pkg::ADDR_W'(r_prod_addr))
                                              : '0;
                    o_used_bytes      <= fbpa_pkg::BYTES_W'(r_prod_used);
                    o_peak_bytes      <= fbpa_pkg::BYTES_W'(r_prod_peak);
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/fixed_block_pool_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_unit
// pool of equal blocks kept as a lifo free list of block indices
// ----------------------------------------------------------------------------
//  channel   handshake                     payload
//  item in   start / busy                  i_cmd, i_block_index
//  result    o_strobe (one cycle)          o_status, o_granted_index,
//                                          o_granted_address, o_used_bytes,
//                                          o_peak_bytes
//  config    psel/penable/pwrite/pready    paddr, pwdata, prdata
//
//  each item passes the back end in order: stack step, multiply, output register;
//  an accepted item is first held in the queue, and the back end takes the next
//  item only when back in idle after the output register; busy rises only when the
//  two-entry queue is full
//  a reload does not rewrite the stack: a mark over the stack makes untouched entries
//  read as their own index; reset is synchronous, pool empty until the first reload
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fixed_block_pool_allocator_unit #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DFLT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item channel
    input  logic                                start,
    output logic                                busy,
    input  logic [fbpa_pkg::CMD_W-1:0]          i_cmd,
    input  logic [fbpa_pkg::IDX_W-1:0]          i_block_index,
    // result channel
    output logic                                o_strobe,
    output logic [fbpa_pkg::STATUS_W-1:0]       o_status,
    output logic [fbpa_pkg::IDX_W-1:0]          o_granted_index,
    output logic [fbpa_pkg::ADDR_W-1:0]         o_granted_address,
    output logic [fbpa_pkg::BYTES_W-1:0]        o_used_bytes,
    output logic [fbpa_pkg::BYTES_W-1:0]        o_peak_bytes,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fbpa_pkg::PADDR_W-1:0]        paddr,
    input  logic [fbpa_pkg::PDATA_W-1:0]        pwdata,
    output logic [fbpa_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    // configuration registers
    logic [fbpa_pkg::CNT_W-1:0]   r_block_count;
    logic [fbpa_pkg::SIZE_W-1:0]  r_block_size;
    logic [fbpa_pkg::ADDR_W-1:0]  r_base_address;

    logic [1:0]                   w_reg_idx;
    logic                         w_cfg_wr;

    // front to back queue head and pop
    fbpa_pkg::t_q_head            w_head;
    logic                         w_pop;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    // register writes; the host must issue them only while no item is in flight, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count  <= fbpa_pkg::BLOCK_COUNT_RST;
            r_block_size   <= fbpa_pkg::BLOCK_SIZE_RST;
            r_base_address <= fbpa_pkg::BASE_ADDRESS_RST;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                fbpa_pkg::REG_BLOCK_COUNT:  r_block_count  <= pwdata[fbpa_pkg::CNT_W-1:0];
                fbpa_pkg::REG_BLOCK_SIZE:   r_block_size   <= pwdata[fbpa_pkg::SIZE_W-1:0];
                fbpa_pkg::REG_BASE_ADDRESS: r_base_address <= pwdata;
                default: begin
                end
            endcase
        end
    end

    // register readback, unused addresses read zero
    always_comb begin
        case (w_reg_idx)
            fbpa_pkg::REG_BLOCK_COUNT:  prdata = fbpa_pkg::PDATA_W'(r_block_count);
            fbpa_pkg::REG_BLOCK_SIZE:   prdata = fbpa_pkg::PDATA_W'(r_block_size);
            fbpa_pkg::REG_BASE_ADDRESS: prdata = r_base_address;
            default:                    prdata = '0;
        endcase
    end

    // front: accept, decode, queue
    fbpa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_block_index (i_block_index),
        .o_head        (w_head),
        .i_pop         (w_pop)
    );

    // back: stack, counters, address and byte counts
    fbpa_back #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head            (w_head),
        .o_pop             (w_pop),
        .i_block_count     (r_block_count),
        .i_block_size      (r_block_size),
        .i_base_address    (r_base_address),
        .o_strobe          (o_strobe),
        .o_status          (o_status),
        .o_granted_index   (o_granted_index),
        .o_granted_address (o_granted_address),
        .o_used_bytes      (o_used_bytes),
        .o_peak_bytes      (o_peak_bytes)
    );

    // a full queue always has an item for the back end
    `ASSERT_IMP(a_busy_has_work, i_clk, i_rst_n, busy, w_head.valid)

    // results are spaced by the back end sequence, never back to back
    `ASSERT_NXT(a_strobe_single, i_clk, i_rst_n, o_strobe, !o_strobe)

    // an item with a non-ok status grants nothing
    `ASSERT_IMP(a_no_grant_on_error, i_clk, i_rst_n,
                o_strobe && (o_status != fbpa_pkg::ST_OK),
                (o_granted_index == '0) && (o_granted_address == '0))

endmodule
